@@ sv/gst_pkg.sv @@
// Shared types, constants and codes of the grouped statistics table.
// No dependencies; used by every other file of the block.
`default_nettype none
package gst_pkg;

    localparam int MAX_CLASSES = 16;
    localparam int SLOT_BITS   = $clog2(MAX_CLASSES);
    localparam int USED_BITS   = SLOT_BITS + 1;
    localparam int KEY_BITS    = 32;
    localparam int SAMPLE_BITS = 16;
    localparam int COUNT_BITS  = 16;
    localparam int SUM_BITS    = 32;
    localparam int SQ_BITS     = 47;
    localparam int MAG_BITS    = 31;
    localparam int VAR_BITS    = 31;
    localparam int DVD_BITS    = COUNT_BITS + SQ_BITS;
    localparam int DVS_BITS    = 2 * COUNT_BITS;
    localparam int ITER_BITS   = $clog2(DVD_BITS);
    localparam int IN_BITS     = 56;
    localparam int OUT_BITS    = 136;

    localparam logic [COUNT_BITS-1:0] COUNT_MAX = {COUNT_BITS{1'b1}};

    localparam logic [1:0] OP_ADD   = 2'd0;
    localparam logic [1:0] OP_READ  = 2'd1;
    localparam logic [1:0] OP_CLEAR = 2'd2;

    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_FULL  = 2'd1;
    localparam logic [1:0] ST_SAT   = 2'd2;
    localparam logic [1:0] ST_EMPTY = 2'd3;

    typedef enum logic [1:0] {
        SRC_IDX   = 2'd0,
        SRC_RSLOT = 2'd1,
        SRC_NONE  = 2'd2
    } res_src_t;

    typedef enum logic [14:0] {
        S_IDLE  = 15'b000000000000001,
        S_DEC   = 15'b000000000000010,
        S_SRCH  = 15'b000000000000100,
        S_KWAIT = 15'b000000000001000,
        S_KCMP  = 15'b000000000010000,
        S_RWAIT = 15'b000000000100000,
        S_RLOAD = 15'b000000001000000,
        S_MUL1  = 15'b000000010000000,
        S_MUL2  = 15'b000000100000000,
        S_SUBT  = 15'b000001000000000,
        S_DIVM  = 15'b000010000000000,
        S_WAITM = 15'b000100000000000,
        S_DIVV  = 15'b001000000000000,
        S_WAITV = 15'b010000000000000,
        S_DONE  = 15'b100000000000000
    } state_t;

    typedef struct packed {
        logic       load_in;
        logic       clr_idx;
        logic       inc_idx;
        logic       addr_idx;
        logic       addr_rslot;
        logic       write_new;
        logic       write_upd;
        logic       load_work;
        logic       zero_stats;
        logic       clear_tab;
        logic       mul1;
        logic       mul2;
        logic       subt;
        logic       div_start;
        logic       div_var;
        logic       take_mean;
        logic       take_var;
        logic       res_set;
        res_src_t   res_src;
        logic       res_new;
        logic [1:0] res_status;
        logic       out_load;
    } cmd_t;

    typedef struct packed {
        logic [1:0] op;
        logic       idx_lt_used;
        logic       full;
        logic       key_match;
        logic       cnt_sat;
        logic       rslot_ok;
        logic       div_done;
        logic       out_free;
    } sts_t;

endpackage
`default_nettype wire

@@ sv/gst_div.sv @@
// Restoring divider, one quotient bit per cycle.
// Depends on gst_pkg for operand widths.
`default_nettype none
module gst_div
(
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic                         start,
    input  wire logic [gst_pkg::DVD_BITS-1:0] dividend,
    input  wire logic [gst_pkg::DVS_BITS-1:0] divisor,
    output logic                              done,
    output logic [gst_pkg::DVD_BITS-1:0]      quotient
);

    localparam logic [gst_pkg::ITER_BITS-1:0] ITER_LAST =
        gst_pkg::ITER_BITS'(gst_pkg::DVD_BITS - 1);

    logic [gst_pkg::DVD_BITS-1:0]  dq_reg;
    logic [gst_pkg::DVS_BITS-1:0]  rem_reg;
    logic [gst_pkg::DVS_BITS-1:0]  dvs_reg;
    logic [gst_pkg::ITER_BITS-1:0] cnt_reg;
    logic                          busy_reg;
    logic                          done_reg;
    logic [gst_pkg::DVS_BITS:0]    rem_sh;
    logic [gst_pkg::DVS_BITS:0]    diff;
    logic                          ge;

    // trial subtraction
    always_comb
    begin
        rem_sh = {rem_reg, dq_reg[gst_pkg::DVD_BITS-1]};
        diff   = rem_sh - {1'b0, dvs_reg};
        ge     = (rem_sh >= {1'b0, dvs_reg});
    end

    // iteration control and shift registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
            dq_reg   <= '0;
            rem_reg  <= '0;
            dvs_reg  <= '0;
        end
        else if (start)
        begin
            busy_reg <= 1'b1;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
            dq_reg   <= dividend;
            rem_reg  <= '0;
            dvs_reg  <= divisor;
        end
        else if (busy_reg)
        begin
            rem_reg <= ge ? diff[gst_pkg::DVS_BITS-1:0] : rem_sh[gst_pkg::DVS_BITS-1:0];
            dq_reg  <= {dq_reg[gst_pkg::DVD_BITS-2:0], ge};
            cnt_reg <= cnt_reg + 1'b1;
            if (cnt_reg == ITER_LAST)
            begin
                busy_reg <= 1'b0;
                done_reg <= 1'b1;
            end
        end
        else
        begin
            done_reg <= 1'b0;
        end
    end

    assign done     = done_reg;
    assign quotient = dq_reg;

endmodule
`default_nettype wire

@@ sv/gst_datapath.sv @@
// Datapath: slot memories, working registers, multipliers, divider and
// output register. Depends on gst_pkg and gst_div.
`default_nettype none
module gst_datapath
(
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire gst_pkg::cmd_t               cmd,
    output gst_pkg::sts_t                    sts,
    input  wire logic [gst_pkg::IN_BITS-1:0] in_data,
    output logic                             out_valid,
    input  wire logic                        out_ready,
    output logic [gst_pkg::OUT_BITS-1:0]     out_data
);

    // slot memories
    logic [gst_pkg::KEY_BITS-1:0]          key_mem [gst_pkg::MAX_CLASSES];
    logic [gst_pkg::COUNT_BITS-1:0]        cnt_mem [gst_pkg::MAX_CLASSES];
    logic signed [gst_pkg::SUM_BITS-1:0]   sum_mem [gst_pkg::MAX_CLASSES];
    logic [gst_pkg::SQ_BITS-1:0]           sq_mem  [gst_pkg::MAX_CLASSES];
    logic signed [gst_pkg::SAMPLE_BITS-1:0] min_mem [gst_pkg::MAX_CLASSES];
    logic signed [gst_pkg::SAMPLE_BITS-1:0] max_mem [gst_pkg::MAX_CLASSES];

    logic [gst_pkg::KEY_BITS-1:0]           rd_key;
    logic [gst_pkg::COUNT_BITS-1:0]         rd_cnt;
    logic signed [gst_pkg::SUM_BITS-1:0]    rd_sum;
    logic [gst_pkg::SQ_BITS-1:0]            rd_sq;
    logic signed [gst_pkg::SAMPLE_BITS-1:0] rd_min;
    logic signed [gst_pkg::SAMPLE_BITS-1:0] rd_max;

    // input item
    logic [1:0]                             op_reg;
    logic [gst_pkg::KEY_BITS-1:0]           key_reg;
    logic signed [gst_pkg::SAMPLE_BITS-1:0] smp_reg;
    logic [gst_pkg::SLOT_BITS-1:0]          rslot_reg;

    logic [gst_pkg::USED_BITS-1:0]          used_reg;
    logic [gst_pkg::USED_BITS-1:0]          idx_reg;
    logic [gst_pkg::SLOT_BITS-1:0]          addr_reg;

    // working statistics
    logic [gst_pkg::COUNT_BITS-1:0]         w_cnt_reg;
    logic signed [gst_pkg::SUM_BITS-1:0]    w_sum_reg;
    logic [gst_pkg::SQ_BITS-1:0]            w_sq_reg;
    logic signed [gst_pkg::SAMPLE_BITS-1:0] w_min_reg;
    logic signed [gst_pkg::SAMPLE_BITS-1:0] w_max_reg;
    logic [gst_pkg::DVD_BITS-1:0]           prod_a_reg;
    logic [gst_pkg::DVD_BITS-1:0]           prod_b_reg;
    logic [gst_pkg::DVS_BITS-1:0]           nsq_reg;
    logic [gst_pkg::DVD_BITS-1:0]           num_reg;
    logic signed [gst_pkg::SAMPLE_BITS-1:0] mean_reg;
    logic [gst_pkg::VAR_BITS-1:0]           var_reg;

    logic [gst_pkg::SLOT_BITS-1:0]          res_idx_reg;
    logic                                   res_new_reg;
    logic [1:0]                             res_st_reg;

    logic                                   ov_reg;
    logic [gst_pkg::OUT_BITS-1:0]           od_reg;

    logic [gst_pkg::MAG_BITS-1:0]           mag;
    logic [2*gst_pkg::SAMPLE_BITS-1:0]      xsq;
    logic signed [2*gst_pkg::SAMPLE_BITS-1:0] xsq_s;
    logic [gst_pkg::DVD_BITS-1:0]           div_dvd;
    logic [gst_pkg::DVS_BITS-1:0]           div_dvs;
    logic                                   div_done;
    logic [gst_pkg::DVD_BITS-1:0]           div_q;
    logic [gst_pkg::SAMPLE_BITS-1:0]        q_lo;
    logic [gst_pkg::SLOT_BITS-1:0]          res_idx_next;

    // sample square, sum magnitude
    always_comb
    begin
        xsq_s = smp_reg * smp_reg;
        xsq   = xsq_s;
        if (w_sum_reg < 0)
            mag = gst_pkg::MAG_BITS'(-w_sum_reg);
        else
            mag = gst_pkg::MAG_BITS'(w_sum_reg);
    end

    // memory write and registered read
    always_ff @(posedge clk)
    begin
        if (cmd.write_new)
        begin
            key_mem[used_reg[gst_pkg::SLOT_BITS-1:0]] <= key_reg;
            cnt_mem[used_reg[gst_pkg::SLOT_BITS-1:0]] <= gst_pkg::COUNT_BITS'(1);
            sum_mem[used_reg[gst_pkg::SLOT_BITS-1:0]] <= gst_pkg::SUM_BITS'(smp_reg);
            sq_mem[used_reg[gst_pkg::SLOT_BITS-1:0]]  <= gst_pkg::SQ_BITS'(xsq);
            min_mem[used_reg[gst_pkg::SLOT_BITS-1:0]] <= smp_reg;
            max_mem[used_reg[gst_pkg::SLOT_BITS-1:0]] <= smp_reg;
        end
        else if (cmd.write_upd)
        begin
            cnt_mem[idx_reg[gst_pkg::SLOT_BITS-1:0]] <= rd_cnt + 1'b1;
            sum_mem[idx_reg[gst_pkg::SLOT_BITS-1:0]] <=
                rd_sum + gst_pkg::SUM_BITS'(smp_reg);
            sq_mem[idx_reg[gst_pkg::SLOT_BITS-1:0]]  <= rd_sq + gst_pkg::SQ_BITS'(xsq);
            min_mem[idx_reg[gst_pkg::SLOT_BITS-1:0]] <= (smp_reg < rd_min) ? smp_reg : rd_min;
            max_mem[idx_reg[gst_pkg::SLOT_BITS-1:0]] <= (smp_reg > rd_max) ? smp_reg : rd_max;
        end
        rd_key <= key_mem[addr_reg];
        rd_cnt <= cnt_mem[addr_reg];
        rd_sum <= sum_mem[addr_reg];
        rd_sq  <= sq_mem[addr_reg];
        rd_min <= min_mem[addr_reg];
        rd_max <= max_mem[addr_reg];
    end

    // divider operand selection
    always_comb
    begin
        if (cmd.div_var)
        begin
            div_dvd = num_reg;
            div_dvs = nsq_reg;
        end
        else
        begin
            div_dvd = gst_pkg::DVD_BITS'(mag);
            div_dvs = gst_pkg::DVS_BITS'(w_cnt_reg);
        end
        q_lo = div_q[gst_pkg::SAMPLE_BITS-1:0];
    end

    gst_div u_div
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (cmd.div_start),
        .dividend (div_dvd),
        .divisor  (div_dvs),
        .done     (div_done),
        .quotient (div_q)
    );

    // result index source
    always_comb
    begin
        case (cmd.res_src)
            gst_pkg::SRC_IDX:   res_idx_next = idx_reg[gst_pkg::SLOT_BITS-1:0];
            gst_pkg::SRC_RSLOT: res_idx_next = rslot_reg;
            default:            res_idx_next = '0;
        endcase
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            used_reg <= '0;
            idx_reg  <= '0;
            ov_reg   <= 1'b0;
        end
        else
        begin
            if (cmd.clear_tab)
                used_reg <= '0;
            else if (cmd.write_new)
                used_reg <= used_reg + 1'b1;
            if (cmd.clr_idx)
                idx_reg <= '0;
            else if (cmd.inc_idx)
                idx_reg <= idx_reg + 1'b1;
            else if (cmd.write_new)
                idx_reg <= used_reg;
            if (cmd.out_load)
                ov_reg <= 1'b1;
            else if (out_ready)
                ov_reg <= 1'b0;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (cmd.load_in)
        begin
            op_reg    <= in_data[1:0];
            key_reg   <= in_data[33:2];
            smp_reg   <= in_data[49:34];
            rslot_reg <= in_data[53:50];
        end
        if (cmd.addr_idx)
            addr_reg <= idx_reg[gst_pkg::SLOT_BITS-1:0];
        else if (cmd.addr_rslot)
            addr_reg <= rslot_reg;
        if (cmd.zero_stats)
        begin
            w_cnt_reg <= '0;
            w_sum_reg <= '0;
            w_sq_reg  <= '0;
            w_min_reg <= '0;
            w_max_reg <= '0;
            mean_reg  <= '0;
            var_reg   <= '0;
        end
        else if (cmd.write_new)
        begin
            w_cnt_reg <= gst_pkg::COUNT_BITS'(1);
            w_sum_reg <= gst_pkg::SUM_BITS'(smp_reg);
            w_sq_reg  <= gst_pkg::SQ_BITS'(xsq);
            w_min_reg <= smp_reg;
            w_max_reg <= smp_reg;
        end
        else if (cmd.write_upd)
        begin
            w_cnt_reg <= rd_cnt + 1'b1;
            w_sum_reg <= rd_sum + gst_pkg::SUM_BITS'(smp_reg);
            w_sq_reg  <= rd_sq + gst_pkg::SQ_BITS'(xsq);
            w_min_reg <= (smp_reg < rd_min) ? smp_reg : rd_min;
            w_max_reg <= (smp_reg > rd_max) ? smp_reg : rd_max;
        end
        else if (cmd.load_work)
        begin
            w_cnt_reg <= rd_cnt;
            w_sum_reg <= rd_sum;
            w_sq_reg  <= rd_sq;
            w_min_reg <= rd_min;
            w_max_reg <= rd_max;
        end
        else
        begin
            if (cmd.take_mean)
                mean_reg <= (w_sum_reg < 0) ? -q_lo : q_lo;
            if (cmd.take_var)
                var_reg <= div_q[gst_pkg::VAR_BITS-1:0];
        end
        // count*sumsq, then sum^2 and count^2
        if (cmd.mul1)
            prod_a_reg <= w_cnt_reg * w_sq_reg;
        if (cmd.mul2)
        begin
            prod_b_reg <= gst_pkg::DVD_BITS'(mag * mag);
            nsq_reg    <= w_cnt_reg * w_cnt_reg;
        end
        if (cmd.subt)
            num_reg <= prod_a_reg - prod_b_reg;
        if (cmd.res_set)
        begin
            res_idx_reg <= res_idx_next;
            res_new_reg <= cmd.res_new;
            res_st_reg  <= cmd.res_status;
        end
        if (cmd.out_load)
            od_reg <= {2'b00, w_max_reg, w_min_reg, var_reg, mean_reg, w_sum_reg,
                       w_cnt_reg, res_st_reg, res_new_reg, res_idx_reg};
    end

    // status to controller
    always_comb
    begin
        sts.op          = op_reg;
        sts.idx_lt_used = (idx_reg < used_reg);
        sts.full        = (used_reg == gst_pkg::USED_BITS'(gst_pkg::MAX_CLASSES));
        sts.key_match   = (rd_key == key_reg);
        sts.cnt_sat     = (rd_cnt == gst_pkg::COUNT_MAX);
        sts.rslot_ok    = (gst_pkg::USED_BITS'(rslot_reg) < used_reg);
        sts.div_done    = div_done;
        sts.out_free    = !ov_reg || out_ready;
    end

    assign out_valid = ov_reg;
    assign out_data  = od_reg;

endmodule
`default_nettype wire

@@ sv/gst_ctrl.sv @@
// Controller state machine: sequences search, update, read and the two
// divisions. Depends on gst_pkg.
`default_nettype none
module gst_ctrl
(
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          in_valid,
    output logic               in_ready,
    input  wire gst_pkg::sts_t sts,
    output gst_pkg::cmd_t      cmd
);

    gst_pkg::state_t state_reg;
    gst_pkg::state_t state_next;

    // next state and commands
    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        cmd.res_src = gst_pkg::SRC_NONE;
        in_ready   = (state_reg == gst_pkg::S_IDLE);
        case (state_reg)
            gst_pkg::S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.load_in = 1'b1;
                    state_next  = gst_pkg::S_DEC;
                end
            end
            gst_pkg::S_DEC:
            begin
                case (sts.op)
                    gst_pkg::OP_ADD:
                    begin
                        cmd.clr_idx = 1'b1;
                        state_next  = gst_pkg::S_SRCH;
                    end
                    gst_pkg::OP_READ:
                    begin
                        cmd.res_set     = 1'b1;
                        cmd.res_src     = gst_pkg::SRC_RSLOT;
                        if (sts.rslot_ok)
                        begin
                            cmd.res_status = gst_pkg::ST_OK;
                            cmd.addr_rslot = 1'b1;
                            state_next     = gst_pkg::S_RWAIT;
                        end
                        else
                        begin
                            cmd.res_status = gst_pkg::ST_EMPTY;
                            cmd.zero_stats = 1'b1;
                            state_next     = gst_pkg::S_DONE;
                        end
                    end
                    gst_pkg::OP_CLEAR:
                    begin
                        cmd.clear_tab  = 1'b1;
                        cmd.res_set    = 1'b1;
                        cmd.res_status = gst_pkg::ST_OK;
                        cmd.zero_stats = 1'b1;
                        state_next     = gst_pkg::S_DONE;
                    end
                    default:
                    begin
                        cmd.res_set    = 1'b1;
                        cmd.res_status = gst_pkg::ST_OK;
                        cmd.zero_stats = 1'b1;
                        state_next     = gst_pkg::S_DONE;
                    end
                endcase
            end
            gst_pkg::S_SRCH:
            begin
                if (sts.idx_lt_used)
                begin
                    cmd.addr_idx = 1'b1;
                    state_next   = gst_pkg::S_KWAIT;
                end
                else if (sts.full)
                begin
                    cmd.res_set    = 1'b1;
                    cmd.res_status = gst_pkg::ST_FULL;
                    cmd.zero_stats = 1'b1;
                    state_next     = gst_pkg::S_DONE;
                end
                else
                begin
                    // open a new slot; index taken next cycle
                    cmd.write_new = 1'b1;
                    state_next    = gst_pkg::S_RLOAD;
                end
            end
            gst_pkg::S_KWAIT:
            begin
                state_next = gst_pkg::S_KCMP;
            end
            gst_pkg::S_KCMP:
            begin
                if (sts.key_match)
                begin
                    cmd.res_set = 1'b1;
                    cmd.res_src = gst_pkg::SRC_IDX;
                    if (sts.cnt_sat)
                    begin
                        cmd.res_status = gst_pkg::ST_SAT;
                        cmd.load_work  = 1'b1;
                    end
                    else
                    begin
                        cmd.res_status = gst_pkg::ST_OK;
                        cmd.write_upd  = 1'b1;
                    end
                    state_next = gst_pkg::S_MUL1;
                end
                else
                begin
                    cmd.inc_idx = 1'b1;
                    state_next  = gst_pkg::S_SRCH;
                end
            end
            gst_pkg::S_RWAIT:
            begin
                state_next = gst_pkg::S_RLOAD;
            end
            gst_pkg::S_RLOAD:
            begin
                // read item loads the slot; new slot only sets its result fields
                if (sts.op == gst_pkg::OP_READ)
                begin
                    cmd.load_work = 1'b1;
                end
                else
                begin
                    cmd.res_set    = 1'b1;
                    cmd.res_src    = gst_pkg::SRC_IDX;
                    cmd.res_new    = 1'b1;
                    cmd.res_status = gst_pkg::ST_OK;
                end
                state_next = gst_pkg::S_MUL1;
            end
            gst_pkg::S_MUL1:
            begin
                cmd.mul1   = 1'b1;
                state_next = gst_pkg::S_MUL2;
            end
            gst_pkg::S_MUL2:
            begin
                cmd.mul2   = 1'b1;
                state_next = gst_pkg::S_SUBT;
            end
            gst_pkg::S_SUBT:
            begin
                cmd.subt   = 1'b1;
                state_next = gst_pkg::S_DIVM;
            end
            gst_pkg::S_DIVM:
            begin
                cmd.div_start = 1'b1;
                state_next    = gst_pkg::S_WAITM;
            end
            gst_pkg::S_WAITM:
            begin
                if (sts.div_done)
                begin
                    cmd.take_mean = 1'b1;
                    state_next    = gst_pkg::S_DIVV;
                end
            end
            gst_pkg::S_DIVV:
            begin
                cmd.div_start = 1'b1;
                cmd.div_var   = 1'b1;
                state_next    = gst_pkg::S_WAITV;
            end
            gst_pkg::S_WAITV:
            begin
                if (sts.div_done)
                begin
                    cmd.take_var = 1'b1;
                    state_next   = gst_pkg::S_DONE;
                end
            end
            gst_pkg::S_DONE:
            begin
                if (sts.out_free)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = gst_pkg::S_IDLE;
                end
            end
            default:
            begin
                state_next = gst_pkg::S_IDLE;
            end
        endcase
    end

    // state register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= gst_pkg::S_IDLE;
        else
            state_reg <= state_next;
    end

endmodule
`default_nettype wire

@@ sv/grouped_statistics_table.sv @@
// Top level of the grouped statistics table: controller plus datapath.
// Depends on gst_pkg, gst_ctrl, gst_datapath (and gst_div below it).
//
// One transaction is processed at a time. The input is ready only while the
// controller idles. Clear, unused opcodes and reads of an empty slot go from
// decode straight to the done state. An add searches the occupied slots in
// turn, through S_SRCH, S_KWAIT and S_KCMP for each slot, and an add refused
// because the table is full goes to the done state once all slots are
// searched. A read of an occupied slot passes S_RWAIT and S_RLOAD; an add
// that opens a slot passes S_RLOAD. Every add that lands in a slot and every
// read of an occupied slot then runs two multiply steps, a subtraction and
// two divisions on the shared bit-serial divider (mean, then variance). Each
// division yields 63 quotient bits, so the divider dominates the time that a
// transaction takes. The result sits in an output register, so a finished
// transaction may wait there while the next one is worked on. The next
// result stalls in its last cycle only while the previous one has not been
// taken. No clearing pass is needed after reset.
`default_nettype none
module grouped_statistics_table
(
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic         s_tvalid,
    output logic              s_tready,
    // opcode[1:0], class_key[33:2], sample[49:34], read_slot[53:50], zero pad
    input  wire logic [55:0]  s_tdata,
    output logic              m_tvalid,
    input  wire logic         m_tready,
    // class_index[3:0], new_class[4], status[6:5], count[22:7], total[54:23],
    // mean[70:55], variance[101:71], minimum[117:102], maximum[133:118], pad
    output logic [135:0]      m_tdata
);

    gst_pkg::cmd_t cmd;
    gst_pkg::sts_t sts;

    gst_ctrl u_ctrl
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_tvalid),
        .in_ready (s_tready),
        .sts      (sts),
        .cmd      (cmd)
    );

    gst_datapath u_dp
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .sts       (sts),
        .in_data   (s_tdata),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_data  (m_tdata)
    );

    // one transaction at a time
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready |=> !s_tready)
        else $error("input taken again straight after a transaction");

    // a new slot is never opened in a full table
    a_no_overfill: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.write_new |-> !sts.full)
        else $error("slot opened with table full");

    // divider done never follows a start directly
    a_div_latency: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.div_start |=> !sts.div_done)
        else $error("divider finished too early");

    // result loaded only into a free output register
    a_out_free: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.out_load |-> sts.out_free)
        else $error("result overwritten before it was taken");

endmodule
`default_nettype wire

@@ sim/grouped_statistics_table_test.sv @@
// Self-checking testbench for the grouped statistics table.
// Depends on gst_pkg and grouped_statistics_table; drives stream transactions,
// predicts every result in a local model of the class table and compares.
`default_nettype none
module grouped_statistics_table_test;

    localparam int IDLE_LIMIT = 20000;
    localparam int RANDOM_ITEMS = 2000;
    localparam logic [1:0] OP_UNUSED = 2'd3;

    typedef struct packed {
        logic [1:0]  op;
        logic [31:0] key;
        logic [15:0] smp;
        logic [3:0]  slot;
    } request_t;

    // Result fields, highest bits first as they sit on m_tdata
    typedef struct packed {
        logic [15:0] maximum;
        logic [15:0] minimum;
        logic [30:0] variance;
        logic [15:0] mean;
        logic [31:0] total;
        logic [15:0] count;
        logic [1:0]  status;
        logic        fresh;
        logic [3:0]  index;
    } stats_t;

    // Directed row: request, plus a typed-in result where it is obvious
    typedef struct {
        request_t req;
        logic     fixed;
        stats_t   res;
    } row_t;

    logic         clk = 1'b0;
    logic         rst_n;
    logic         s_tvalid;
    logic         s_tready;
    logic [55:0]  s_tdata;
    logic         m_tvalid;
    logic         m_tready;
    logic [135:0] m_tdata;

    grouped_statistics_table dut (
        .clk(clk), .rst_n(rst_n),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
    );

    // Predictor state
    int unsigned      used_slots;
    logic [31:0]      tab_key [gst_pkg::MAX_CLASSES];
    int unsigned      tab_count [gst_pkg::MAX_CLASSES];
    longint           tab_sum [gst_pkg::MAX_CLASSES];
    longint unsigned  tab_sq [gst_pkg::MAX_CLASSES];
    longint           tab_min [gst_pkg::MAX_CLASSES];
    longint           tab_max [gst_pkg::MAX_CLASSES];

    stats_t      expected_results[$];
    row_t        rows[$];
    int          mismatches = 0;
    int          results_seen = 0;
    int          idle_cycles;
    int          send_gap_pct;
    int          take_stall_pct;

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    function automatic stats_t slot_statistics(int unsigned s);
        stats_t          r;
        longint unsigned n;
        longint unsigned mag;
        longint unsigned q;
        longint unsigned v;
        r = '0;
        n = tab_count[s];
        mag = (tab_sum[s] < 0) ? longint'(-tab_sum[s]) : longint'(tab_sum[s]);
        q = 0;
        v = 0;
        if (n != 0)
        begin
            q = mag / n;
            v = (n * tab_sq[s] - mag * mag) / (n * n);
        end
        if (tab_sum[s] < 0)
            q = -q;
        r.count = n[15:0];
        r.total = tab_sum[s][31:0];
        r.mean = q[15:0];
        r.variance = v[30:0];
        r.minimum = tab_min[s][15:0];
        r.maximum = tab_max[s][15:0];
        return r;
    endfunction

    // Fold one request into the table and return the result it causes
    function automatic stats_t apply_request(request_t q);
        stats_t          r;
        int unsigned     s;
        longint          x;
        longint unsigned m;
        r = '0;
        x = longint'($signed(q.smp));
        m = (x < 0) ? longint'(-x) : longint'(x);
        if (q.op == gst_pkg::OP_ADD)
        begin
            s = used_slots;
            for (int i = 0; i < int'(used_slots); i++)
                if (tab_key[i] == q.key && s == used_slots)
                    s = i;
            if (s == used_slots)
            begin
                if (used_slots >= gst_pkg::MAX_CLASSES)
                begin
                    r.status = gst_pkg::ST_FULL;
                    return r;
                end
                used_slots++;
                tab_key[s] = q.key;
                tab_count[s] = 1;
                tab_sum[s] = x;
                tab_sq[s] = m * m;
                tab_min[s] = x;
                tab_max[s] = x;
                r = slot_statistics(s);
                r.fresh = 1'b1;
            end
            else if (tab_count[s] >= 65535)
            begin
                r = slot_statistics(s);
                r.status = gst_pkg::ST_SAT;
            end
            else
            begin
                tab_count[s]++;
                tab_sum[s] += x;
                tab_sq[s] += m * m;
                if (x < tab_min[s]) tab_min[s] = x;
                if (x > tab_max[s]) tab_max[s] = x;
                r = slot_statistics(s);
            end
            r.index = s[3:0];
        end
        else if (q.op == gst_pkg::OP_READ)
        begin
            if (q.slot >= used_slots)
                r.status = gst_pkg::ST_EMPTY;
            else
                r = slot_statistics(q.slot);
            r.index = q.slot;
        end
        else if (q.op == gst_pkg::OP_CLEAR)
            used_slots = 0;
        return r;
    endfunction

    task automatic report_mismatch(string what, longint got, longint want);
        $display("mismatch on result %0d: %s got %0h expected %0h",
                 results_seen, what, got, want);
        mismatches++;
    endtask

    // Send one transaction, with random gaps before it; valid stays high
    // afterwards until the next call or the end of the stimulus drops it
    task automatic send_request(request_t q);
        while ($urandom_range(99) < send_gap_pct)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= {2'b00, q.slot, q.smp, q.key, q.op};
        expected_results.insert(expected_results.size(), apply_request(q));
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
    endtask

    function automatic void add_row(request_t q, logic fixed, stats_t res);
        row_t r;
        r.req = q;
        r.fixed = fixed;
        r.res = res;
        rows.insert(rows.size(), r);
    endfunction

    // Result side: random stalls and comparison
    always @(posedge clk)
    begin
        stats_t got;
        stats_t want;
        if (rst_n)
        begin
            m_tready <= ($urandom_range(99) >= take_stall_pct);
            if (m_tvalid && m_tready)
            begin
                got = m_tdata[133:0];
                results_seen++;
                if (expected_results.size() == 0)
                    report_mismatch("unexpected result", 1, 0);
                else
                begin
                    want = expected_results.pop_front();
                    if (got.index != want.index)
                        report_mismatch("class_index", got.index, want.index);
                    if (got.fresh != want.fresh)
                        report_mismatch("new_class", got.fresh, want.fresh);
                    if (got.status != want.status)
                        report_mismatch("status", got.status, want.status);
                    if (got.count != want.count)
                        report_mismatch("count", got.count, want.count);
                    if (got.total != want.total)
                        report_mismatch("total", got.total, want.total);
                    if (got.mean != want.mean)
                        report_mismatch("mean", got.mean, want.mean);
                    if (got.variance != want.variance)
                        report_mismatch("variance", got.variance, want.variance);
                    if (got.minimum != want.minimum)
                        report_mismatch("minimum", got.minimum, want.minimum);
                    if (got.maximum != want.maximum)
                        report_mismatch("maximum", got.maximum, want.maximum);
                end
            end
        end
        else
        begin
            m_tready <= 1'b0;
        end
    end

    // Watchdog: cycles with no transaction on either side
    always @(posedge clk)
    begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || !rst_n)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("watchdog expired, %0d results outstanding",
                     expected_results.size());
            $display("TEST FAILED");
            $finish;
        end
    end

    function automatic request_t make_request(logic [1:0] op, logic [31:0] key,
                                              logic [15:0] smp, logic [3:0] slot);
        request_t q;
        q.op = op;
        q.key = key;
        q.smp = smp;
        q.slot = slot;
        return q;
    endfunction

    // Random request: mostly adds, over a small key pool when pool is at most 16, some reads, clears and unused opcodes
    function automatic request_t random_request(int pool);
        int unsigned pick;
        logic [31:0] key;
        logic [15:0] smp;
        pick = $urandom_range(99);
        if (pool > 16 || $urandom_range(9) == 0)
            key = $urandom();
        else
            key = 32'hA000_0000 + $urandom_range(pool - 1);
        case ($urandom_range(3))
            0: smp = $urandom_range(1) ? 16'h7FFF : 16'h8000;
            default: smp = 16'($urandom());
        endcase
        if (pick < 60)
            return make_request(gst_pkg::OP_ADD, key, smp, 4'($urandom()));
        else if (pick < 93)
            return make_request(gst_pkg::OP_READ, $urandom(), 16'($urandom()),
                                4'($urandom()));
        else if (pick < 97)
            return make_request(gst_pkg::OP_CLEAR, $urandom(), 16'($urandom()),
                                4'($urandom()));
        return make_request(OP_UNUSED, $urandom(), 16'($urandom()), 4'($urandom()));
    endfunction

    initial
    begin
        row_t     r;
        stats_t   want;
        stats_t   full_res;
        stats_t   last;
        int       pool;
        rst_n = 1'b0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        send_gap_pct = 6;
        take_stall_pct = 64;
        used_slots = 0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed table: empty reads, extremes, unused opcode, clear, a full table
        want = '0;
        want.status = gst_pkg::ST_EMPTY;
        want.index = 4'd0;
        add_row(make_request(gst_pkg::OP_READ, '0, '0, 4'd0), 1'b1, want);
        want.index = 4'd15;
        add_row(make_request(gst_pkg::OP_READ, '1, '1, 4'd15), 1'b1, want);
        add_row(make_request(OP_UNUSED, '1, '1, '1), 1'b1, '0);
        add_row(make_request(gst_pkg::OP_CLEAR, '1, '1, '1), 1'b1, '0);
        add_row(make_request(gst_pkg::OP_ADD, 32'h0, 16'h8000, 4'd0), 1'b0, '0);
        add_row(make_request(gst_pkg::OP_ADD, 32'h0, 16'h7FFF, 4'd0), 1'b0, '0);
        add_row(make_request(gst_pkg::OP_ADD, 32'hFFFF_FFFF, 16'h0, 4'd0), 1'b0, '0);
        add_row(make_request(gst_pkg::OP_ADD, 32'hFFFF_FFFF, 16'hFFFF, 4'd0), 1'b0, '0);
        add_row(make_request(gst_pkg::OP_READ, '0, '0, 4'd0), 1'b0, '0);
        add_row(make_request(gst_pkg::OP_READ, '0, '0, 4'd1), 1'b0, '0);
        add_row(make_request(gst_pkg::OP_READ, '0, '0, 4'd2), 1'b0, '0);
        for (int k = 0; k < 14; k++)
            add_row(make_request(gst_pkg::OP_ADD, 32'h5555_0000 + k, 16'(k * 4099),
                                 4'd0), 1'b0, '0);
        full_res = '0;
        full_res.status = gst_pkg::ST_FULL;
        add_row(make_request(gst_pkg::OP_ADD, 32'h1234_5678, 16'h0001, 4'd0), 1'b1,
                full_res);
        add_row(make_request(gst_pkg::OP_READ, '0, '0, 4'd15), 1'b0, '0);
        add_row(make_request(gst_pkg::OP_CLEAR, '0, '0, 4'd0), 1'b1, '0);

        foreach (rows[i])
        begin
            r = rows[i];
            send_request(r.req);
            last = expected_results[$];
            if (r.fixed && last != r.res)
                report_mismatch($sformatf("directed row %0d", i),
                                longint'(last[63:0]), longint'(r.res[63:0]));
        end

        // Random part in three idling phases
        for (int ph = 0; ph < 3; ph++)
        begin
            send_gap_pct = (ph == 0) ? 6 : (ph == 1) ? 64 : 0;
            take_stall_pct = (ph == 0) ? 64 : (ph == 1) ? 6 : 0;
            for (int k = 0; k < RANDOM_ITEMS / 3; k++)
            begin
                pool = (k % 200 < 100) ? 8 : 20;
                send_request(random_request(pool));
            end
        end
        s_tvalid <= 1'b0;

        while (expected_results.size() != 0)
            @(posedge clk);
        repeat (200) @(posedge clk);

        $display("covered %0d results: directed extremes, a full table and",
                 results_seen);
        $display("random add/read/clear traffic under sender and receiver stalls");
        if (mismatches == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end
endmodule
`default_nettype wire

@@ grouped_statistics_table.f @@
sv/gst_pkg.sv
sv/gst_div.sv
sv/gst_datapath.sv
sv/gst_ctrl.sv
sv/grouped_statistics_table.sv
sim/grouped_statistics_table_test.sv
